FILE: design/twes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twes_pkg
// Shared widths and codes of the timing wheel event scheduler.
// ----------------------------------------------------------------------------
package twes_pkg;

    localparam int TIME_W = 32;
    localparam int TAG_W  = 16;
    localparam int ACT_W  = 2;
    localparam int KIND_W = 2;

    typedef logic [TIME_W-1:0] time_t;
    typedef logic [TAG_W-1:0]  tag_t;
    typedef logic [ACT_W-1:0]  act_t;
    typedef logic [KIND_W-1:0] kind_t;

    localparam act_t ACT_SCHED = 2'd0;
    localparam act_t ACT_EXEC  = 2'd1;
    localparam act_t ACT_CLEAR = 2'd2;
    localparam act_t ACT_INIT  = 2'd3;

    localparam kind_t KIND_FIRED  = 2'd0;
    localparam kind_t KIND_SCHED  = 2'd1;
    localparam kind_t KIND_REJECT = 2'd2;
    localparam kind_t KIND_ACK    = 2'd3;

endpackage

FILE: design/timing_wheel_event_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timing_wheel_event_scheduler_core
// Timed event buffer: schedule, execute up to a time, clear and init.
// ----------------------------------------------------------------------------
// Events are kept in a node memory of NODES entries with one read port and one
// write port; a live bit per node marks the pool occupancy and every scan walks
// the node memory one entry per cycle. A schedule makes one full memory pass;
// a rejected schedule, an execute with a target in the past, a clear and an
// init go straight to their result with no pass. An execute that fires k events
// makes one full memory pass per fired event plus a final pass that finds
// nothing left. Events of equal time leave in arrival order, kept by a
// per-node rank among live events of the same time. The output is
// registered, so a new item is taken while the final result still waits.
module timing_wheel_event_scheduler_core #(
    parameter int NODES = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [47:0]                 s_tdata,   // event_time[31:0], event_tag[47:32]
    input  twes_pkg::act_t              s_tuser,   // action[1:0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [47:0]                 m_tdata,   // fired_tag[15:0], fired_time[47:16]
    output twes_pkg::kind_t             m_tuser,   // result_kind[1:0]
    output logic                        m_tlast
);
    import twes_pkg::*;

    localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CW = $clog2(NODES + 1);
    localparam int MW = TIME_W + TAG_W + IW;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic             op_exec_reg, op_exec_next;
    time_t            next_time_reg, next_time_next;
    time_t            arg_time_reg, arg_time_next;
    tag_t             arg_tag_reg, arg_tag_next;
    logic [IW-1:0]    free_idx_reg, free_idx_next;
    logic [NODES-1:0] valid_reg, valid_next;
    logic [CW-1:0]    iss_cnt_reg, iss_cnt_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [IW-1:0]    rd_idx_reg, rd_idx_next;
    logic [MW-1:0]    rd_data_reg;
    logic [IW-1:0]    eq_cnt_reg, eq_cnt_next;
    logic             found_reg, found_next;
    time_t            best_off_reg, best_off_next;
    logic [IW-1:0]    best_rank_reg, best_rank_next;
    logic [IW-1:0]    best_idx_reg, best_idx_next;
    tag_t             best_tag_reg, best_tag_next;
    time_t            best_time_reg, best_time_next;
    logic             pend_vld_reg, pend_vld_next;
    tag_t             pend_tag_reg, pend_tag_next;
    time_t            pend_time_reg, pend_time_next;
    kind_t            res_kind_reg, res_kind_next;
    tag_t             res_tag_reg, res_tag_next;
    time_t            res_time_reg, res_time_next;
    logic             res_last_reg, res_last_next;
    logic             m_valid_reg, m_valid_next;
    kind_t            m_kind_reg, m_kind_next;
    tag_t             m_tag_reg, m_tag_next;
    time_t            m_time_reg, m_time_next;
    logic             m_last_reg, m_last_next;

    logic [MW-1:0]    node_mem [NODES];
    logic             mem_we;
    logic [IW-1:0]    rd_addr;

    time_t            in_time, clamp_time, in_span, span, off, d_time, diff;
    tag_t             in_tag, d_tag;
    logic [IW-1:0]    d_rank, first_free;
    logic             live, pool_full, out_free;

    assign in_time   = s_tdata[TIME_W-1:0];
    assign in_tag    = s_tdata[TIME_W +: TAG_W];
    assign diff      = next_time_reg - in_time;
    // event in the past by wrap difference is moved up to the current time
    assign clamp_time = (diff != '0 && !diff[TIME_W-1]) ? next_time_reg : in_time;
    assign in_span   = in_time - next_time_reg;
    assign span      = arg_time_reg - next_time_reg;
    assign d_time    = rd_data_reg[TIME_W-1:0];
    assign d_tag     = rd_data_reg[TIME_W +: TAG_W];
    assign d_rank    = rd_data_reg[TIME_W+TAG_W +: IW];
    assign off       = d_time - next_time_reg;
    assign live      = valid_reg[rd_idx_reg];
    assign pool_full = &valid_reg;
    assign out_free  = !m_valid_reg || m_tready;
    assign rd_addr   = iss_cnt_reg[IW-1:0];

    always_comb begin
        first_free = '0;
        for (int i = NODES - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                first_free = IW'(i);
            end
        end
    end

    // rank includes the last node of the pass, counted in the same cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            node_mem[free_idx_reg] <= {eq_cnt_next, arg_tag_reg, arg_time_reg};
        end
        rd_data_reg <= node_mem[rd_addr];
    end

    always_comb begin
        state_next     = state_reg;
        op_exec_next   = op_exec_reg;
        next_time_next = next_time_reg;
        arg_time_next  = arg_time_reg;
        arg_tag_next   = arg_tag_reg;
        free_idx_next  = free_idx_reg;
        valid_next     = valid_reg;
        iss_cnt_next   = iss_cnt_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        eq_cnt_next    = eq_cnt_reg;
        found_next     = found_reg;
        best_off_next  = best_off_reg;
        best_rank_next = best_rank_reg;
        best_idx_next  = best_idx_reg;
        best_tag_next  = best_tag_reg;
        best_time_next = best_time_reg;
        pend_vld_next  = pend_vld_reg;
        pend_tag_next  = pend_tag_reg;
        pend_time_next = pend_time_reg;
        res_kind_next  = res_kind_reg;
        res_tag_next   = res_tag_reg;
        res_time_next  = res_time_reg;
        res_last_next  = res_last_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_kind_next    = m_kind_reg;
        m_tag_next     = m_tag_reg;
        m_time_next    = m_time_reg;
        m_last_next    = m_last_reg;
        mem_we         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    res_last_next = 1'b1;
                    res_tag_next  = '0;
                    res_kind_next = KIND_ACK;
                    case (s_tuser)
                        ACT_SCHED: begin
                            arg_time_next = clamp_time;
                            arg_tag_next  = in_tag;
                            if (pool_full) begin
                                res_kind_next = KIND_REJECT;
                                res_tag_next  = in_tag;
                                res_time_next = clamp_time;
                                state_next    = ST_EMIT;
                            end else begin
                                free_idx_next = first_free;
                                eq_cnt_next   = '0;
                                iss_cnt_next  = '0;
                                op_exec_next  = 1'b0;
                                state_next    = ST_SCAN;
                            end
                        end
                        ACT_EXEC: begin
                            if (in_span[TIME_W-1]) begin
                                res_time_next = next_time_reg;
                                state_next    = ST_EMIT;
                            end else begin
                                arg_time_next = in_time;
                                found_next    = 1'b0;
                                pend_vld_next = 1'b0;
                                iss_cnt_next  = '0;
                                op_exec_next  = 1'b1;
                                state_next    = ST_SCAN;
                            end
                        end
                        ACT_CLEAR: begin
                            valid_next    = '0;
                            res_time_next = next_time_reg;
                            state_next    = ST_EMIT;
                        end
                        default: begin
                            valid_next     = '0;
                            next_time_next = in_time;
                            res_time_next  = in_time;
                            state_next     = ST_EMIT;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (iss_cnt_reg < CW'(NODES)) begin
                    rd_vld_next  = 1'b1;
                    rd_idx_next  = rd_addr;
                    iss_cnt_next = iss_cnt_reg + 1'b1;
                end
                if (rd_vld_reg) begin
                    if (!op_exec_reg) begin
                        if (live && d_time == arg_time_reg) begin
                            eq_cnt_next = eq_cnt_reg + 1'b1;
                        end
                    end else if (live && off <= span &&
                                 (!found_reg || off < best_off_reg ||
                                  (off == best_off_reg && d_rank < best_rank_reg))) begin
                        found_next     = 1'b1;
                        best_off_next  = off;
                        best_rank_next = d_rank;
                        best_idx_next  = rd_idx_reg;
                        best_tag_next  = d_tag;
                        best_time_next = d_time;
                    end
                    if (rd_idx_reg == IW'(NODES - 1)) begin
                        rd_vld_next = 1'b0;
                        if (!op_exec_reg) begin
                            mem_we                   = 1'b1;
                            valid_next[free_idx_reg] = 1'b1;
                            res_kind_next            = KIND_SCHED;
                            res_tag_next             = arg_tag_reg;
                            res_time_next            = arg_time_reg;
                            res_last_next            = 1'b1;
                            state_next               = ST_EMIT;
                        end else if (found_next) begin
                            // hold the earliest event until the next pass tells if it is last
                            valid_next[best_idx_next] = 1'b0;
                            pend_vld_next  = 1'b1;
                            pend_tag_next  = best_tag_next;
                            pend_time_next = best_time_next;
                            found_next     = 1'b0;
                            iss_cnt_next   = '0;
                            if (pend_vld_reg) begin
                                res_kind_next = KIND_FIRED;
                                res_tag_next  = pend_tag_reg;
                                res_time_next = pend_time_reg;
                                res_last_next = 1'b0;
                                state_next    = ST_EMIT;
                            end
                        end else begin
                            next_time_next = arg_time_reg + 1'b1;
                            res_last_next  = 1'b1;
                            state_next     = ST_EMIT;
                            if (pend_vld_reg) begin
                                pend_vld_next = 1'b0;
                                res_kind_next = KIND_FIRED;
                                res_tag_next  = pend_tag_reg;
                                res_time_next = pend_time_reg;
                            end else begin
                                res_kind_next = KIND_ACK;
                                res_tag_next  = '0;
                                res_time_next = arg_time_reg + 1'b1;
                            end
                        end
                    end
                end
            end

            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = res_kind_reg;
                    m_tag_next   = res_tag_reg;
                    m_time_next  = res_time_reg;
                    m_last_next  = res_last_reg;
                    state_next   = res_last_reg ? ST_IDLE : ST_SCAN;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            next_time_reg <= '0;
            valid_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            pend_vld_reg  <= 1'b0;
            found_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            next_time_reg <= next_time_next;
            valid_reg     <= valid_next;
            rd_vld_reg    <= rd_vld_next;
            pend_vld_reg  <= pend_vld_next;
            found_reg     <= found_next;
            m_valid_reg   <= m_valid_next;
        end
        op_exec_reg   <= op_exec_next;
        arg_time_reg  <= arg_time_next;
        arg_tag_reg   <= arg_tag_next;
        free_idx_reg  <= free_idx_next;
        iss_cnt_reg   <= iss_cnt_next;
        rd_idx_reg    <= rd_idx_next;
        eq_cnt_reg    <= eq_cnt_next;
        best_off_reg  <= best_off_next;
        best_rank_reg <= best_rank_next;
        best_idx_reg  <= best_idx_next;
        best_tag_reg  <= best_tag_next;
        best_time_reg <= best_time_next;
        pend_tag_reg  <= pend_tag_next;
        pend_time_reg <= pend_time_next;
        res_kind_reg  <= res_kind_next;
        res_tag_reg   <= res_tag_next;
        res_time_reg  <= res_time_next;
        res_last_reg  <= res_last_next;
        m_kind_reg    <= m_kind_next;
        m_tag_reg     <= m_tag_next;
        m_time_reg    <= m_time_next;
        m_last_reg    <= m_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {m_time_reg, m_tag_reg};
    assign m_tlast  = m_last_reg;

    a_clear_empties_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == ACT_CLEAR || s_tuser == ACT_INIT))
        |=> valid_reg == '0)
        else $error("pool not emptied after clear or init");

    a_reject_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && res_kind_reg == KIND_REJECT) |-> pool_full)
        else $error("schedule rejected with a free node");

    a_fire_needs_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && res_kind_reg == KIND_FIRED && !res_last_reg)
        |-> pend_vld_reg)
        else $error("non-final fired result without a held event");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timing wheel event scheduler core.
// Drives schedule, execute, clear and init transactions, predicts every
// result with a behavioral copy of the wheel and compares field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import twes_pkg::*;

    localparam int NODES = 64;
    localparam int SLOTS = 256;
    localparam int SHIFT = 8;
    localparam int NIL   = NODES;
    localparam longint LIMIT = 3000000;

    typedef struct packed {
        kind_t kind;
        tag_t  tag;
        time_t tm;
        logic  last;
    } result_t;

    typedef struct packed {
        act_t  act;
        time_t tm;
        tag_t  tag;
        logic  chk;
        kind_t kind;
        time_t xtime;
    } row_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [47:0] s_tdata = '0;
    act_t s_tuser = ACT_SCHED;
    logic m_tvalid;
    logic m_tready = 0;
    logic [47:0] m_tdata;
    kind_t m_tuser;
    logic m_tlast;

    timing_wheel_event_scheduler_core #(.NODES(NODES)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // wheel state of the predictor
    time_t wheel_now;
    int    head_q[SLOTS];
    int    tail_q[SLOTS];
    time_t ev_time[NODES];
    tag_t  ev_tag[NODES];
    int    nxt[NODES];
    int    prv[NODES];
    int    free_n;

    result_t pending_results[$];
    int  errors = 0;
    int  mismatches = 0;
    int  n_items = 0;
    int  n_fired = 0;
    int  n_reject = 0;
    int  send_idle = 0;
    int  recv_idle = 0;
    bit  hold_recv = 0;
    longint cycles = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic bit is_later(time_t a, time_t b);
        time_t d;
        d = a - b;
        return d != 0 && !d[31];
    endfunction

    function automatic int wheel_slot(time_t t);
        time_t h;
        h = t ^ (t >> SHIFT);
        return int'(h[7:0]);
    endfunction

    function automatic void wheel_flush();
        for (int i = 0; i < SLOTS; i++) begin
            head_q[i] = NIL;
            tail_q[i] = NIL;
        end
        for (int i = 0; i < NODES; i++) nxt[i] = i + 1;
        free_n = 0;
    endfunction

    function automatic void push_result(kind_t k, tag_t g, time_t t, logic l);
        result_t r;
        r.kind = k; r.tag = g; r.tm = t; r.last = l;
        pending_results.push_back(r);
    endfunction

    function automatic void wheel_schedule(time_t t, tag_t g);
        int n, s, p, q;
        if (is_later(wheel_now, t)) t = wheel_now;
        if (free_n >= NODES) begin
            push_result(KIND_REJECT, g, t, 1);
            n_reject++;
            return;
        end
        n = free_n;
        free_n = nxt[n];
        ev_time[n] = t;
        ev_tag[n] = g;
        s = wheel_slot(t);
        p = tail_q[s];
        while (p != NIL && is_later(ev_time[p], t)) p = prv[p];
        q = (p == NIL) ? head_q[s] : nxt[p];
        prv[n] = p;
        nxt[n] = q;
        if (p == NIL) head_q[s] = n; else nxt[p] = n;
        if (q == NIL) tail_q[s] = n; else prv[q] = n;
        push_result(KIND_SCHED, g, t, 1);
    endfunction

    function automatic void wheel_execute(time_t target);
        time_t span, off, best_off;
        int k, best, best_s, p, q;
        span = target - wheel_now;
        if (span[31]) begin
            push_result(KIND_ACK, '0, wheel_now, 1);
            return;
        end
        k = 0;
        while (k < NODES) begin
            best = NIL; best_off = 0; best_s = 0;
            for (int s = 0; s < SLOTS; s++) begin
                for (int n = head_q[s]; n != NIL; n = nxt[n]) begin
                    off = ev_time[n] - wheel_now;
                    if (off <= span && (best == NIL || off < best_off)) begin
                        best = n; best_off = off; best_s = s;
                    end
                end
            end
            if (best == NIL) break;
            p = prv[best]; q = nxt[best];
            if (p == NIL) head_q[best_s] = q; else nxt[p] = q;
            if (q == NIL) tail_q[best_s] = p; else prv[q] = p;
            nxt[best] = free_n;
            free_n = best;
            push_result(KIND_FIRED, ev_tag[best], ev_time[best], 0);
            n_fired++;
            k++;
        end
        wheel_now = target + 1;
        if (k == 0) push_result(KIND_ACK, '0, wheel_now, 1);
        else pending_results[$].last = 1;
    endfunction

    function automatic void wheel_apply(act_t a, time_t t, tag_t g);
        case (a)
            ACT_SCHED: wheel_schedule(t, g);
            ACT_EXEC: wheel_execute(t);
            ACT_CLEAR: begin
                wheel_flush();
                push_result(KIND_ACK, '0, wheel_now, 1);
            end
            default: begin
                wheel_flush();
                wheel_now = t;
                push_result(KIND_ACK, '0, wheel_now, 1);
            end
        endcase
    endfunction

    // valid drops at one falling edge and rises no earlier than the next one
    task automatic send_item(act_t a, time_t t, tag_t g);
        do @(negedge aclk);
        while (send_idle > 0 && $urandom_range(99) < send_idle);
        s_tvalid <= 1;
        s_tuser <= a;
        s_tdata <= {g, t};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        wheel_apply(a, t, g);
        n_items++;
        @(negedge aclk);
        s_tvalid <= 0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    // receiver ready
    always @(negedge aclk) begin
        if (hold_recv) m_tready <= 0;
        else m_tready <= !($urandom_range(99) < recv_idle);
    end

    // result check
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected transaction kind=%0d data=%h", m_tuser, m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.kind || m_tdata[15:0] !== want.tag
                    || m_tdata[47:16] !== want.tm || m_tlast !== want.last) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch exp k=%0d tag=%h t=%h l=%b got k=%0d tag=%h t=%h l=%b",
                                 want.kind, want.tag, want.tm, want.last,
                                 m_tuser, m_tdata[15:0], m_tdata[47:16], m_tlast);
                end
            end
        end
    end

    row_t directed[] = '{
        '{ACT_EXEC,  32'd10,         16'h0000, 1'b1, KIND_ACK,   32'd11},
        '{ACT_SCHED, 32'd0,          16'hFFFF, 1'b1, KIND_SCHED, 32'd11},
        '{ACT_SCHED, 32'd20,         16'h0001, 1'b1, KIND_SCHED, 32'd20},
        '{ACT_SCHED, 32'd20,         16'h0002, 1'b1, KIND_SCHED, 32'd20},
        '{ACT_SCHED, 32'd15,         16'h0003, 1'b1, KIND_SCHED, 32'd15},
        '{ACT_SCHED, 32'h0000_1415,  16'h0004, 1'b0, KIND_ACK,   32'd0},
        '{ACT_EXEC,  32'd5,          16'h0000, 1'b1, KIND_ACK,   32'd11},
        '{ACT_EXEC,  32'd30,         16'h0000, 1'b0, KIND_ACK,   32'd0},
        '{ACT_EXEC,  32'd40,         16'h0000, 1'b1, KIND_ACK,   32'd41},
        '{ACT_INIT,  32'hFFFF_FFF0,  16'h5A5A, 1'b1, KIND_ACK,   32'hFFFF_FFF0},
        '{ACT_SCHED, 32'hFFFF_FFFF,  16'h00AA, 1'b1, KIND_SCHED, 32'hFFFF_FFFF},
        '{ACT_SCHED, 32'h0000_0004,  16'h00BB, 1'b1, KIND_SCHED, 32'h0000_0004},
        '{ACT_SCHED, 32'h8000_0000,  16'h00CC, 1'b0, KIND_ACK,   32'd0},
        '{ACT_EXEC,  32'h0000_0008,  16'hFFFF, 1'b0, KIND_ACK,   32'd0},
        '{ACT_SCHED, 32'h0000_0100,  16'h8001, 1'b0, KIND_ACK,   32'd0},
        '{ACT_CLEAR, 32'hFFFF_FFFF,  16'hFFFF, 1'b1, KIND_ACK,   32'h0000_0009},
        '{ACT_EXEC,  32'h7FFF_FFFF,  16'h0000, 1'b1, KIND_ACK,   32'h8000_0000},
        '{ACT_INIT,  32'd0,          16'h0000, 1'b1, KIND_ACK,   32'd0}
    };

    // random stimulus with a live window near the wheel time
    task automatic random_item(int shape);
        int r;
        time_t t;
        r = $urandom_range(99);
        t = wheel_now + $urandom_range(shape);
        if ($urandom_range(19) == 0) t = $urandom;
        if (r < 70) send_item(ACT_SCHED, t, tag_t'($urandom));
        else if (r < 93) send_item(ACT_EXEC, t, tag_t'($urandom));
        else if (r < 97) send_item(ACT_CLEAR, $urandom, tag_t'($urandom));
        else send_item(ACT_INIT, $urandom, tag_t'($urandom));
    endtask

    initial begin
        wheel_now = 0;
        wheel_flush();
        repeat (11) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        send_idle = 26; recv_idle = 73;
        foreach (directed[i]) begin
            send_item(directed[i].act, directed[i].tm, directed[i].tag);
            // typed-in value overrides the predicted last entry
            if (directed[i].chk) begin
                pending_results[$].kind = directed[i].kind;
                pending_results[$].tm = directed[i].xtime;
            end
        end
        drain();

        // fill the pool past capacity, with the receiver held off at the start
        hold_recv = 1;
        fork
            begin
                repeat (300) @(negedge aclk);
                hold_recv = 0;
            end
            for (int i = 0; i < 70; i++)
                send_item(ACT_SCHED, wheel_now + $urandom_range(600), tag_t'($urandom));
        join
        send_item(ACT_EXEC, wheel_now + 700, 16'h0);
        drain();

        for (int i = 0; i < 90; i++) random_item(300);
        drain();
        send_idle = 73; recv_idle = 26;
        for (int i = 0; i < 90; i++) random_item(300);
        drain();
        send_idle = 0; recv_idle = 0;
        for (int i = 0; i < 90; i++) random_item(2000);
        drain();

        $display("%0d transactions in, %0d events fired, %0d rejected on a full pool",
                 n_items, n_fired, n_reject);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d results outstanding", errors, pending_results.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/twes_pkg.sv
design/timing_wheel_event_scheduler_core.sv
bench/tb_top.sv
